>>> src/dpt_pkg.sv
// ============================================================================
// Dashed polyline tessellator package
// Widths, register indexes and the shared record types of the tessellator.
// ============================================================================
`default_nettype none

package dpt_pkg;

    // Coordinate and difference widths (signed Q16.16, difference one bit wider).
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;

    // Configuration field widths.
    localparam int RES_W   = 6;
    localparam int SOLID_W = 8;
    localparam int SEG_W   = 10;

    // Result field widths.
    localparam int TEX_W   = 17;
    localparam int IDX_W   = 16;
    localparam int PHASE_W = 9;

    // Default upper limit of the points per segment.
    localparam int MAX_RESOLUTION_DEF = 63;

    // Depth of the segment queue between the front and the back part.
    localparam int SEG_FIFO_DEPTH = 2;

    // Texture coordinate of one in Q1.16.
    localparam logic [TEX_W-1:0] TEX_ONE = 17'h10000;

    // Register port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_RESOLUTION    = 2'd0;
    localparam reg_idx_t REG_SOLID_LEN     = 2'd1;
    localparam reg_idx_t REG_GAP_LEN       = 2'd2;
    localparam reg_idx_t REG_SEGMENT_COUNT = 2'd3;

    typedef struct packed {
        logic [RES_W-1:0]   resolution;
        logic [SOLID_W-1:0] solid_len;
        logic [SOLID_W-1:0] gap_len;
        logic [SEG_W-1:0]   segment_count;
    } cfg_t;

    // One segment to tessellate: its start vertex and its exact difference.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
        logic                      fin;
    } seg_t;

endpackage

`default_nettype wire

>>> src/dpt_div.sv
// ============================================================================
// Dashed polyline tessellator divider lane
// Bit-serial restoring division of a signed value by a small unsigned divisor,
// giving the floor quotient and a remainder in the range zero to divisor-1.
// ============================================================================
`default_nettype none

module dpt_div #(
    parameter int DW = dpt_pkg::DIFF_W,
    parameter int RW = dpt_pkg::RES_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] dividend,
    input  wire logic        [RW-1:0] divisor,
    output logic                      done,
    output logic signed [DW-1:0]      quotient,
    output logic        [RW-1:0]      remainder
);
    import dpt_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] mag_reg;
    logic [RW-1:0] rem_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;

    logic [RW:0]   rem_w;
    logic          ge;
    logic [RW:0]   rem_sub;
    logic          stepping;

    assign stepping = run_reg && (cnt_reg != CW'(DW));
    assign rem_w    = {rem_reg, mag_reg[DW-1]};
    assign ge       = rem_w >= {1'b0, divisor};
    assign rem_sub  = rem_w - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end else if (stepping) begin
            cnt_reg <= cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mag_reg <= dividend[DW-1] ? (DW'(0) - dividend) : dividend;
            neg_reg <= dividend[DW-1];
            rem_reg <= '0;
        end else if (stepping) begin
            mag_reg <= {mag_reg[DW-2:0], ge};
            rem_reg <= ge ? rem_sub[RW-1:0] : rem_w[RW-1:0];
        end
    end

    // Magnitude quotient and remainder are turned into floor form for negatives.
    assign done      = run_reg && (cnt_reg == CW'(DW));
    assign quotient  = !neg_reg ? mag_reg :
                       (rem_reg == '0) ? (DW'(0) - mag_reg) : ~mag_reg;
    assign remainder = (neg_reg && rem_reg != '0) ? (divisor - rem_reg) : rem_reg;

endmodule

`default_nettype wire

>>> src/dpt_fifo.sv
// ============================================================================
// Dashed polyline tessellator segment queue
// Small first-in first-out buffer; the depth must be a power of two.
// ============================================================================
`default_nettype none

module dpt_fifo #(
    parameter int WIDTH = $bits(dpt_pkg::seg_t),
    parameter int DEPTH = dpt_pkg::SEG_FIFO_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  room,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  avail
);
    import dpt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign room     = count_reg != NW'(DEPTH);
    assign avail    = count_reg != '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> src/dpt_front.sv
// ============================================================================
// Dashed polyline tessellator front end
// Accepts vertices, keeps the previous one and queues one segment per vertex
// that closes a segment.
// ============================================================================
`default_nettype none

module dpt_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [dpt_pkg::COORD_W-1:0] s_vx,
    input  wire logic signed [dpt_pkg::COORD_W-1:0] s_vy,
    input  wire logic signed [dpt_pkg::COORD_W-1:0] s_vz,
    input  wire logic                               s_final_vertex,
    input  wire logic                               fifo_room,
    output logic                                    seg_push,
    output dpt_pkg::seg_t                           seg_data
);
    import dpt_pkg::*;

    logic                      have_prev_reg, have_prev_next;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic                      accept;

    assign s_ready  = fifo_room;
    assign accept   = s_valid && s_ready;
    assign seg_push = accept && have_prev_reg;

    assign seg_data.x   = prev_x_reg;
    assign seg_data.y   = prev_y_reg;
    assign seg_data.z   = prev_z_reg;
    assign seg_data.dx  = {s_vx[COORD_W-1], s_vx} - {prev_x_reg[COORD_W-1], prev_x_reg};
    assign seg_data.dy  = {s_vy[COORD_W-1], s_vy} - {prev_y_reg[COORD_W-1], prev_y_reg};
    assign seg_data.dz  = {s_vz[COORD_W-1], s_vz} - {prev_z_reg[COORD_W-1], prev_z_reg};
    assign seg_data.fin = s_final_vertex;

    // A final vertex closes the line; a lone final vertex is simply dropped.
    always_comb begin
        have_prev_next = have_prev_reg;
        if (accept) begin
            have_prev_next = !s_final_vertex;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else begin
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_x_reg <= s_vx;
            prev_y_reg <= s_vy;
            prev_z_reg <= s_vz;
        end
    end

endmodule

`default_nettype wire

>>> src/dpt_back.sv
// ============================================================================
// Dashed polyline tessellator back end
// Divides each segment difference once, then steps the interpolation and the
// dash pattern one point per cycle into the output register unless stalled.
// ============================================================================
`default_nettype none

module dpt_back #(
    parameter int MAX_RESOLUTION = dpt_pkg::MAX_RESOLUTION_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dpt_pkg::cfg_t                 cfg,
    input  wire logic                          seg_valid,
    input  wire dpt_pkg::seg_t                 seg_data,
    output logic                               seg_pop,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [dpt_pkg::COORD_W-1:0] m_px,
    output logic signed [dpt_pkg::COORD_W-1:0] m_py,
    output logic signed [dpt_pkg::COORD_W-1:0] m_pz,
    output logic [dpt_pkg::TEX_W-1:0]          m_tex_coord,
    output logic [dpt_pkg::IDX_W-1:0]          m_point_index,
    output logic                               m_dash_start,
    output logic [dpt_pkg::IDX_W-1:0]          m_dash_length,
    output logic                               m_drawn,
    output logic                               m_last
);
    import dpt_pkg::*;

    localparam int IW     = $clog2(MAX_RESOLUTION + 1);
    localparam int NCOORD = 3;
    localparam int NLANE  = NCOORD + 1;
    localparam int TEX_LN = NCOORD;
    localparam logic [RES_W-1:0] MAX_R = RES_W'(MAX_RESOLUTION);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Effective resolution and total point count of the line.
    logic [RES_W-1:0] r_eff;
    logic [SEG_W-1:0] seg_eff;
    logic [IDX_W-1:0] total_eff;

    // Per-segment registers.
    logic [RES_W-1:0]          r_reg;
    logic [IDX_W-1:0]          total_reg;
    logic                      fin_reg;
    logic [IW-1:0]             i_reg;
    logic signed [COORD_W-1:0] p1_reg     [NCOORD];
    logic signed [DIFF_W-1:0]  qd_reg     [NCOORD];
    logic [RES_W-1:0]          rd_reg     [NCOORD];
    logic signed [DIFF_W-1:0]  acc_q_reg  [NCOORD];
    logic [RES_W-1:0]          acc_rem_reg[NCOORD];
    logic [TEX_W-1:0]          qt_reg, tex_q_reg;
    logic [RES_W-1:0]          rt_reg, tex_rem_reg;

    // Divider lanes: three coordinates and the texture step.
    logic signed [DIFF_W-1:0] div_dividend[NLANE];
    logic signed [DIFF_W-1:0] div_q       [NLANE];
    logic [RES_W-1:0]         div_r       [NLANE];
    logic [NLANE-1:0]         div_done;
    logic                     all_done;

    // Stepping logic.
    logic                      emit_fire;
    logic                      last_pt;
    logic                      rnd        [NCOORD];
    logic signed [COORD_W-1:0] pt         [NCOORD];
    logic [RES_W:0]            rem_sum    [NCOORD];
    logic [RES_W:0]            rem_wrap   [NCOORD];
    logic                      carry      [NCOORD];
    logic [RES_W:0]            trem_sum, trem_wrap;
    logic                      tcarry;

    // Dash pattern.
    logic [IDX_W-1:0]   point_cnt_reg, point_cnt_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [PHASE_W-1:0] period;
    logic [IDX_W-1:0]   solid16;
    logic               single_dash;
    logic [IDX_W-1:0]   remaining;
    logic [IDX_W-1:0]   dash_len_cut;
    logic [PHASE_W:0]   phase_inc;
    logic               d_start;
    logic [IDX_W-1:0]   d_len;
    logic               d_drawn;
    logic [PHASE_W-1:0] d_phase;

    logic m_valid_reg, m_valid_next;

    // ---------------------------------------------------------------- setup
    always_comb begin
        if (cfg.resolution == '0) begin
            r_eff = RES_W'(1);
        end else if (cfg.resolution > MAX_R) begin
            r_eff = MAX_R;
        end else begin
            r_eff = cfg.resolution;
        end
        seg_eff   = (cfg.segment_count == '0) ? SEG_W'(1) : cfg.segment_count;
        total_eff = IDX_W'(seg_eff) * IDX_W'(r_eff) + IDX_W'(1);
    end

    assign seg_pop = (state_reg == ST_IDLE) && seg_valid;

    assign div_dividend[0]      = seg_data.dx;
    assign div_dividend[1]      = seg_data.dy;
    assign div_dividend[2]      = seg_data.dz;
    assign div_dividend[TEX_LN] = DIFF_W'(TEX_ONE);

    for (genvar g = 0; g < NLANE; g++) begin : g_div
        dpt_div #(
            .DW (DIFF_W),
            .RW (RES_W)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .start     (seg_pop),
            .dividend  (div_dividend[g]),
            .divisor   (r_reg),
            .done      (div_done[g]),
            .quotient  (div_q[g]),
            .remainder (div_r[g])
        );
    end

    assign all_done = &div_done;

    // ---------------------------------------------------------------- stepping
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);
    assign last_pt   = fin_reg ? (RES_W'(i_reg) == r_reg)
                               : (RES_W'(i_reg) == r_reg - RES_W'(1));

    always_comb begin
        for (int k = 0; k < NCOORD; k++) begin
            rnd[k]      = {acc_rem_reg[k], 1'b0} >= {1'b0, r_reg};
            pt[k]       = COORD_W'({p1_reg[k][COORD_W-1], p1_reg[k]} + acc_q_reg[k]
                                   + DIFF_W'(rnd[k]));
            rem_sum[k]  = {1'b0, acc_rem_reg[k]} + {1'b0, rd_reg[k]};
            rem_wrap[k] = rem_sum[k] - {1'b0, r_reg};
            carry[k]    = rem_sum[k] >= {1'b0, r_reg};
        end
        trem_sum  = {1'b0, tex_rem_reg} + {1'b0, rt_reg};
        trem_wrap = trem_sum - {1'b0, r_reg};
        tcarry    = trem_sum >= {1'b0, r_reg};
    end

    // ---------------------------------------------------------------- dash
    always_comb begin
        period       = {1'b0, cfg.solid_len} + {1'b0, cfg.gap_len};
        solid16      = IDX_W'(cfg.solid_len);
        single_dash  = (period == '0) || (total_reg <= solid16);
        remaining    = (point_cnt_reg < total_reg) ? (total_reg - point_cnt_reg) : solid16;
        dash_len_cut = (remaining < solid16) ? remaining : solid16;
        phase_inc    = {1'b0, phase_reg} + (PHASE_W + 1)'(1);
        if (single_dash) begin
            d_start = point_cnt_reg == '0;
            d_len   = d_start ? total_reg : '0;
            d_drawn = 1'b1;
            d_phase = '0;
        end else begin
            d_start = phase_reg == '0;
            d_len   = d_start ? dash_len_cut : '0;
            d_drawn = phase_reg < {1'b0, cfg.solid_len};
            d_phase = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PHASE_W-1:0];
        end
    end

    // ---------------------------------------------------------------- control
    always_comb begin
        state_next     = state_reg;
        point_cnt_next = point_cnt_reg;
        phase_next     = phase_reg;
        m_valid_next   = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (seg_valid) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (all_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_fire) begin
                    m_valid_next = 1'b1;
                    if (last_pt && fin_reg) begin
                        point_cnt_next = '0;
                        phase_next     = '0;
                    end else begin
                        point_cnt_next = point_cnt_reg + IDX_W'(1);
                        phase_next     = d_phase;
                    end
                    if (last_pt) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            point_cnt_reg <= '0;
            phase_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            point_cnt_reg <= point_cnt_next;
            phase_reg     <= phase_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge aclk) begin
        if (seg_pop) begin
            p1_reg[0] <= seg_data.x;
            p1_reg[1] <= seg_data.y;
            p1_reg[2] <= seg_data.z;
            fin_reg   <= seg_data.fin;
            r_reg     <= r_eff;
            total_reg <= total_eff;
        end
        if (state_reg == ST_DIV && all_done) begin
            for (int k = 0; k < NCOORD; k++) begin
                qd_reg[k]      <= div_q[k];
                rd_reg[k]      <= div_r[k];
                acc_q_reg[k]   <= '0;
                acc_rem_reg[k] <= '0;
            end
            qt_reg      <= div_q[TEX_LN][TEX_W-1:0];
            rt_reg      <= div_r[TEX_LN];
            tex_q_reg   <= '0;
            tex_rem_reg <= '0;
            i_reg       <= '0;
        end else if (emit_fire) begin
            for (int k = 0; k < NCOORD; k++) begin
                acc_q_reg[k]   <= acc_q_reg[k] + qd_reg[k] + DIFF_W'(carry[k]);
                acc_rem_reg[k] <= carry[k] ? rem_wrap[k][RES_W-1:0] : rem_sum[k][RES_W-1:0];
            end
            tex_q_reg   <= tex_q_reg + qt_reg + TEX_W'(tcarry);
            tex_rem_reg <= tcarry ? trem_wrap[RES_W-1:0] : trem_sum[RES_W-1:0];
            i_reg       <= i_reg + IW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            m_px          <= pt[0];
            m_py          <= pt[1];
            m_pz          <= pt[2];
            m_tex_coord   <= tex_q_reg;
            m_point_index <= point_cnt_reg;
            m_dash_start  <= d_start;
            m_dash_length <= d_len;
            m_drawn       <= d_drawn;
            m_last        <= last_pt;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

>>> src/dashed_polyline_tessellator.sv
// ============================================================================
// Dashed polyline tessellator
// Expands a stream of polyline vertices into interpolated, dash-marked points.
// ============================================================================
//
// Vertices arrive one word at a time on the s_ channel; every vertex after the
// first of a line closes a segment and produces R points on the m_ channel
// (R+1 for the vertex flagged final_vertex, whose extra point is the endpoint
// with texture coordinate one), the last of them flagged m_last. A lone final
// vertex produces nothing. Each segment is first taken from the queue, then
// the bit-serial dividers split the coordinate differences and the texture
// step by R and hand the results over, and the points follow one per cycle
// while the output is not stalled. The front end keeps accepting vertices
// into a two-entry segment queue while the back end works, so short input
// bursts are absorbed. Configuration registers sit on the APB port at byte
// addresses 0 (resolution), 4 (solid_len), 8 (gap_len) and 12 (segment_count),
// and should only be written while the block is idle.
//
`default_nettype none

module dashed_polyline_tessellator #(
    parameter int MAX_RESOLUTION = dpt_pkg::MAX_RESOLUTION_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dpt_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [dpt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [dpt_pkg::APB_DATA_W-1:0]          prdata,
    output logic                                    pready,
    // Vertex input
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [dpt_pkg::COORD_W-1:0] s_vx,
    input  wire logic signed [dpt_pkg::COORD_W-1:0] s_vy,
    input  wire logic signed [dpt_pkg::COORD_W-1:0] s_vz,
    input  wire logic                               s_final_vertex,
    // Point output
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [dpt_pkg::COORD_W-1:0]      m_px,
    output logic signed [dpt_pkg::COORD_W-1:0]      m_py,
    output logic signed [dpt_pkg::COORD_W-1:0]      m_pz,
    output logic [dpt_pkg::TEX_W-1:0]               m_tex_coord,
    output logic [dpt_pkg::IDX_W-1:0]               m_point_index,
    output logic                                    m_dash_start,
    output logic [dpt_pkg::IDX_W-1:0]               m_dash_length,
    output logic                                    m_drawn,
    output logic                                    m_last
);
    import dpt_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. The port never stalls, so a write lands on
    // the access phase; the register index is the word address.
    // ------------------------------------------------------------------
    logic [RES_W-1:0]   resolution_reg;
    logic [SOLID_W-1:0] solid_len_reg;
    logic [SOLID_W-1:0] gap_len_reg;
    logic [SEG_W-1:0]   segment_count_reg;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    cfg_t               cfg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resolution_reg    <= RES_W'(1);
            solid_len_reg     <= '0;
            gap_len_reg       <= '0;
            segment_count_reg <= SEG_W'(1);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RESOLUTION:    resolution_reg    <= pwdata[RES_W-1:0];
                REG_SOLID_LEN:     solid_len_reg     <= pwdata[SOLID_W-1:0];
                REG_GAP_LEN:       gap_len_reg       <= pwdata[SOLID_W-1:0];
                REG_SEGMENT_COUNT: segment_count_reg <= pwdata[SEG_W-1:0];
                default:           ;
            endcase
        end
    end

    // Read back is combinational and zero-extended to the bus width.
    always_comb begin
        unique case (cfg_idx)
            REG_RESOLUTION:    prdata = APB_DATA_W'(resolution_reg);
            REG_SOLID_LEN:     prdata = APB_DATA_W'(solid_len_reg);
            REG_GAP_LEN:       prdata = APB_DATA_W'(gap_len_reg);
            REG_SEGMENT_COUNT: prdata = APB_DATA_W'(segment_count_reg);
            default:           prdata = '0;
        endcase
    end

    assign cfg.resolution    = resolution_reg;
    assign cfg.solid_len     = solid_len_reg;
    assign cfg.gap_len       = gap_len_reg;
    assign cfg.segment_count = segment_count_reg;

    // ------------------------------------------------------------------
    // Front end: keeps the previous vertex and turns each closing vertex
    // into a segment record (start point plus exact difference).
    // ------------------------------------------------------------------
    logic fifo_room;
    logic seg_push;
    seg_t seg_in;

    dpt_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vx           (s_vx),
        .s_vy           (s_vy),
        .s_vz           (s_vz),
        .s_final_vertex (s_final_vertex),
        .fifo_room      (fifo_room),
        .seg_push       (seg_push),
        .seg_data       (seg_in)
    );

    // ------------------------------------------------------------------
    // Segment queue: decouples vertex intake from point generation.
    // ------------------------------------------------------------------
    logic seg_avail;
    logic seg_pop;
    seg_t seg_out;

    dpt_fifo #(
        .WIDTH ($bits(seg_t)),
        .DEPTH (SEG_FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (seg_push),
        .push_data (seg_in),
        .room      (fifo_room),
        .pop       (seg_pop),
        .pop_data  (seg_out),
        .avail     (seg_avail)
    );

    // ------------------------------------------------------------------
    // Back end: divides once per segment, then steps the interpolation,
    // texture coordinate and dash pattern one point per cycle while the
    // output is not stalled. Its output register is the m_ channel.
    // ------------------------------------------------------------------
    dpt_back #(
        .MAX_RESOLUTION (MAX_RESOLUTION)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .seg_valid     (seg_avail),
        .seg_data      (seg_out),
        .seg_pop       (seg_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_px          (m_px),
        .m_py          (m_py),
        .m_pz          (m_pz),
        .m_tex_coord   (m_tex_coord),
        .m_point_index (m_point_index),
        .m_dash_start  (m_dash_start),
        .m_dash_length (m_dash_length),
        .m_drawn       (m_drawn),
        .m_last        (m_last)
    );

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------

    // The output register is empty straight after reset.
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // A texture coordinate of one only ever belongs to the closing endpoint.
    a_endpoint_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tex_coord == TEX_ONE) |-> m_last)
        else $error("endpoint word not marked last");

    // A dash that starts on an undrawn point must be empty.
    a_dash_drawn : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_dash_start && !m_drawn) |-> (m_dash_length == '0))
        else $error("non-empty dash starts on an undrawn point");

endmodule

`default_nettype wire
